/* hw/rtl/quad_x_motor_mixer_core_assert.svh */
// Assertion macros for the quad X motor mixer core.
// Included by the top level; expects clk and rst in scope.
`ifndef QUAD_X_MOTOR_MIXER_CORE_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define QXMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds starting in the cycle after the antecedent.
`define QXMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/qxmm_pkg.sv */
// Shared types and constants for the quad X motor mixer.
// Used by qxmm_mix, qxmm_lane and quad_x_motor_mixer_core.
package qxmm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_THRUST_OFFSET = 3'd0,
    REG_MOMENT_GAIN   = 3'd1,
    REG_THRUST_GAIN   = 3'd2,
    REG_CYCLES_PER_US = 3'd3,
    REG_OUTPUT_READY  = 3'd4
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [11:0] thrust_offset;
    logic [15:0] moment_gain;
    logic [15:0] thrust_gain;
    logic [7:0]  cycles_per_us;
    logic        output_ready;
  } cfg_t;

  // 4 * 0.367 in Q1.16 (0.367 rounds to 24052)
  localparam logic [16:0] MIX_K4 = 17'd96208;

  localparam int FRAC_BITS = 26;
  localparam int SUM_W     = 34;
  localparam int PROD_W    = 51;
  localparam int PULSE_W   = 11;
  localparam int CYC_W     = 19;

  localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

  // Mixed motor thrust, Q16
  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

/* hw/rtl/qxmm_mix.sv */
// Front of the mixer pipeline: offset removal, torque products, X-frame mix.
// Depends on qxmm_pkg; three register stages with their own valid bits.
module qxmm_mix (
  input  logic                clk,
  input  logic                rst,
  input  qxmm_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [11:0]         throttle_us,
  input  logic signed [15:0]  roll_torque,
  input  logic signed [15:0]  pitch_torque,
  input  logic signed [15:0]  yaw_torque,
  output logic                out_valid,
  output qxmm_pkg::sum_t      s1,
  output qxmm_pkg::sum_t      s2,
  output qxmm_pkg::sum_t      s3,
  output qxmm_pkg::sum_t      s4
);
  import qxmm_pkg::*;

  logic               v1, v2, v3;
  logic signed [12:0] d;
  logic signed [16:0] rsum, rdiff;
  logic signed [15:0] yaw1;
  logic signed [29:0] mean;
  logic signed [33:0] a, b;
  logic signed [23:0] y;
  logic signed [30:0] mean_next;
  logic signed [33:0] a_next, b_next;
  sum_t               mean_x, y_x;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: remove the offset, form roll plus and minus pitch
  always_ff @(posedge clk) begin
    if (in_valid) begin
      d     <= $signed({1'b0, throttle_us}) - $signed({1'b0, cfg.thrust_offset});
      rsum  <= 17'(roll_torque) + 17'(pitch_torque);
      rdiff <= 17'(roll_torque) - 17'(pitch_torque);
      yaw1  <= yaw_torque;
    end
  end

  // Stage 2: mean thrust and moment products
  assign mean_next = d * $signed({1'b0, MIX_K4});
  assign a_next    = rsum * $signed({1'b0, cfg.moment_gain});
  assign b_next    = rdiff * $signed({1'b0, cfg.moment_gain});

  always_ff @(posedge clk) begin
    if (v1) begin
      mean <= mean_next[29:0];
      a    <= a_next;
      b    <= b_next;
      y    <= {yaw1, 8'h00};
    end
  end

  // Stage 3: mix into four motor thrusts
  assign mean_x = SUM_W'(mean);
  assign y_x    = SUM_W'(y);

  always_ff @(posedge clk) begin
    if (v2) begin
      s1 <= mean_x - y_x - a;
      s2 <= mean_x - y_x + a;
      s3 <= mean_x + y_x + b;
      s4 <= mean_x + y_x - b;
    end
  end

  assign out_valid = v3;

endmodule

/* hw/rtl/qxmm_lane.sv */
// One motor lane: thrust gain, offset, truncation, clamp and cycle scaling.
// Depends on qxmm_pkg; three register stages enabled by the top's valid bits.
module qxmm_lane (
  input  logic                             clk,
  input  qxmm_pkg::cfg_t                   cfg,
  input  logic [2:0]                       en,
  input  qxmm_pkg::sum_t                   s,
  output logic [qxmm_pkg::CYC_W-1:0]       cycles,
  output logic                             clamped
);
  import qxmm_pkg::*;

  logic signed [PROD_W-1:0]           prod;
  logic signed [PROD_W:0]             p, p_adj, off_x;
  logic signed [PROD_W-FRAC_BITS:0]   q;
  logic [PULSE_W-1:0]                 pulse, pulse_next;
  logic                               clip, clip_next;
  logic [CYC_W-1:0]                   cyc_next;

  // Stage 4: apply the thrust gain
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= PROD_W'(s) * $signed({1'b0, cfg.thrust_gain});
    end
  end

  // Stage 5: add the offset, truncate toward zero, clamp
  assign off_x = $signed({{(PROD_W - 12 - FRAC_BITS + 1){1'b0}}, cfg.thrust_offset,
                          {FRAC_BITS{1'b0}}});
  assign p     = (PROD_W + 1)'(prod) + off_x;
  assign p_adj = p[PROD_W] ? p + (PROD_W + 1)'((64'd1 << FRAC_BITS) - 64'd1) : p;
  assign q     = p_adj[PROD_W:FRAC_BITS];

  always_comb begin
    if (q > $signed((PROD_W - FRAC_BITS + 1)'(PULSE_MAX))) begin
      pulse_next = PULSE_MAX;
      clip_next  = 1'b1;
    end else if (q < $signed((PROD_W - FRAC_BITS + 1)'(PULSE_MIN))) begin
      pulse_next = PULSE_MIN;
      clip_next  = 1'b1;
    end else begin
      pulse_next = q[PULSE_W-1:0];
      clip_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pulse <= pulse_next;
      clip  <= clip_next;
    end
  end

  // Stage 6: convert to timer cycles; drop everything when not ready
  assign cyc_next = CYC_W'(pulse) * CYC_W'(cfg.cycles_per_us);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cycles  <= cfg.output_ready ? cyc_next : '0;
      clamped <= cfg.output_ready & clip;
    end
  end

endmodule

/* hw/rtl/quad_x_motor_mixer_core.sv */
// Quad X motor mixer: six-stage pipeline, one word accepted per cycle.
// Path: start passes valid bits v1 to v5 into done, which rises with the lane outputs; 1 word/cycle.
// busy never rises, and cfg_ready is always high; the receiver cannot stall.
// Multiplier chain: mean and moment products, thrust gain, cycle scaling.
// Reset (rst, synchronous) flushes the pipeline and loads register defaults.
// Depends on qxmm_pkg, qxmm_mix, qxmm_lane and the assertion header.
module quad_x_motor_mixer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        throttle_us,
  input  logic signed [15:0] roll_torque,
  input  logic signed [15:0] pitch_torque,
  input  logic signed [15:0] yaw_torque,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [18:0]        motor1_cycles,
  output logic [18:0]        motor2_cycles,
  output logic [18:0]        motor3_cycles,
  output logic [18:0]        motor4_cycles,
  output logic [3:0]         clamped_mask,
  output logic               not_ready
);
  import qxmm_pkg::*;
  `include "quad_x_motor_mixer_core_assert.svh"

  cfg_t   cfg;
  logic   accept;
  logic   v3, v4, v5;
  sum_t   s [4];
  logic [CYC_W-1:0] cyc [4];
  logic [3:0]       clip;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Hold configuration; take a word on each write handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thrust_offset <= 12'd1000;
      cfg.moment_gain   <= 16'd256;
      cfg.thrust_gain   <= 16'd256;
      cfg.cycles_per_us <= 8'd200;
      cfg.output_ready  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_THRUST_OFFSET: cfg.thrust_offset <= cfg_data[11:0];
        REG_MOMENT_GAIN:   cfg.moment_gain   <= cfg_data;
        REG_THRUST_GAIN:   cfg.thrust_gain   <= cfg_data;
        REG_CYCLES_PER_US: cfg.cycles_per_us <= cfg_data[7:0];
        REG_OUTPUT_READY:  cfg.output_ready  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  qxmm_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (accept),
    .throttle_us  (throttle_us),
    .roll_torque  (roll_torque),
    .pitch_torque (pitch_torque),
    .yaw_torque   (yaw_torque),
    .out_valid    (v3),
    .s1           (s[0]),
    .s2           (s[1]),
    .s3           (s[2]),
    .s4           (s[3])
  );

  // Advance the valid bits of the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // Flag the not-ready result alongside the lane outputs
  always_ff @(posedge clk) begin
    if (v5) begin
      not_ready <= ~cfg.output_ready;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qxmm_lane u_lane (
      .clk     (clk),
      .cfg     (cfg),
      .en      ({v5, v4, v3}),
      .s       (s[i]),
      .cycles  (cyc[i]),
      .clamped (clip[i])
    );
  end

  assign motor1_cycles = cyc[0];
  assign motor2_cycles = cyc[1];
  assign motor3_cycles = cyc[2];
  assign motor4_cycles = cyc[3];
  assign clamped_mask  = clip;

  // A word that enters reaches done through the valid bits v1, v2, v3, v4 and v5
  `QXMM_ASSERT_NEXT(a_latency, accept, ##5 done, "word did not reach the output in six cycles")
  // A not-ready result carries no clamp flags and no pulses on motors 1 and 4
  `QXMM_ASSERT_NOW(a_not_ready_zero, done && not_ready,
    (clamped_mask == 4'd0) && (motor1_cycles == '0) && (motor4_cycles == '0),
    "not-ready result carries pulse data")
  // A clamped motor 1 sits at one of the two limits
  `QXMM_ASSERT_NOW(a_clamp_limit, done && !not_ready && clamped_mask[0],
    (motor1_cycles == CYC_W'(PULSE_MIN) * CYC_W'(cfg.cycles_per_us)) ||
    (motor1_cycles == CYC_W'(PULSE_MAX) * CYC_W'(cfg.cycles_per_us)),
    "clamped motor 1 is off the pulse limits")

endmodule
